>>> hdl/dfk_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dfk_pkg
// Types, constants and a lookup function shared by the forward kinematics block.
// ----------------------------------------------------------------------------
package dfk_pkg;

  localparam int MAX_JOINTS   = 8;
  localparam int JOINT_W      = (MAX_JOINTS > 1) ? $clog2(MAX_JOINTS) : 1;
  localparam int JCNT_W       = $clog2(MAX_JOINTS + 1);
  localparam int ADDR_W       = JOINT_W + 2;
  localparam int DEPTH        = MAX_JOINTS * 4;
  localparam int CORDIC_STEPS = 16;
  localparam int STEP_W       = 4;

  typedef logic signed [35:0] wide_t;
  typedef logic signed [23:0] angle_t;

  localparam wide_t          GAIN_Q30    = 36'sd652032874;
  localparam wide_t          ONE_Q30     = 36'sd1073741824;
  localparam angle_t         PI_Q16      = 24'sd205887;
  localparam logic [33:0]    DEG_FULL    = 34'd23592960;
  localparam logic [33:0]    RED_OFFSET  = 34'd2170552320;
  localparam logic signed [25:0] DEG_FULL_S  = 26'sd23592960;
  localparam logic signed [25:0] DEG_HALF    = 26'sd11796480;
  localparam logic signed [25:0] DEG_QUARTER = 26'sd5898240;
  localparam logic signed [27:0] DEG_TO_RAD  = 28'sd74961321;

  localparam logic [1:0] PSEL_THETA = 2'd0;
  localparam logic [1:0] PSEL_ALPHA = 2'd1;
  localparam logic [1:0] PSEL_LEN   = 2'd2;
  localparam logic [1:0] PSEL_OFS   = 2'd3;

  localparam logic OP_WRITE   = 1'b0;
  localparam logic OP_COMPUTE = 1'b1;

  typedef struct packed {
    logic               opcode;
    logic [2:0]         joint_index;
    logic [1:0]         param_select;
    logic signed [31:0] param_value;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] yaw_angle;
    logic signed [31:0] pitch_angle;
    logic signed [31:0] roll_angle;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
  } out_item_t;

  typedef enum logic {CM_ROTATE, CM_VECTOR} cordic_mode_t;

  typedef enum logic [2:0] {
    C_IDLE, C_REDUCE, C_FOLD, C_SCALE, C_ITER, C_DONE
  } cordic_state_t;

  typedef enum logic [3:0] {
    S_IDLE, S_RD, S_LD, S_TRIG_WT, S_HMUL, S_MAT, S_NEXT, S_SQ,
    S_SQRT_GO, S_SQRT_WT, S_ATAN_GO, S_ATAN_WT, S_OUT
  } ctrl_state_t;

  typedef struct packed {
    logic               start;
    cordic_mode_t       mode;
    logic signed [31:0] angle;
    wide_t              x;
    wide_t              y;
  } cordic_req_t;

  typedef struct packed {
    logic   done;
    wide_t  x;
    wide_t  y;
    angle_t z;
  } cordic_rsp_t;

  function automatic angle_t atan_lut(input logic [STEP_W-1:0] i);
    angle_t a;
    unique case (i)
      4'd0:    a = 24'sd51472;
      4'd1:    a = 24'sd30386;
      4'd2:    a = 24'sd16055;
      4'd3:    a = 24'sd8150;
      4'd4:    a = 24'sd4091;
      4'd5:    a = 24'sd2047;
      4'd6:    a = 24'sd1024;
      4'd7:    a = 24'sd512;
      4'd8:    a = 24'sd256;
      4'd9:    a = 24'sd128;
      4'd10:   a = 24'sd64;
      4'd11:   a = 24'sd32;
      4'd12:   a = 24'sd16;
      4'd13:   a = 24'sd8;
      4'd14:   a = 24'sd4;
      default: a = 24'sd2;
    endcase
    return a;
  endfunction

endpackage

>>> hdl/dfk_param_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dfk_param_ram
// Joint parameter table: one write port, one registered read port, cleared
// entries read as zero through per-entry valid bits.
// ----------------------------------------------------------------------------
module dfk_param_ram (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       we,
  input  logic [dfk_pkg::ADDR_W-1:0] waddr,
  input  logic [31:0]                wdata,
  input  logic [dfk_pkg::ADDR_W-1:0] raddr,
  output logic [31:0]                rdata
);

  logic [31:0]               mem [dfk_pkg::DEPTH];
  logic [dfk_pkg::DEPTH-1:0] valid_r;
  logic [31:0]               rdata_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (we) begin
      valid_r[waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_r <= valid_r[raddr] ? mem[raddr] : 32'd0;
  end

  assign rdata = rdata_r;

endmodule

>>> hdl/dfk_cordic.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dfk_cordic
// Shared iterative CORDIC: degree sin/cos in rotation mode, atan2 in
// vectoring mode, one micro-rotation per cycle.
// ----------------------------------------------------------------------------
module dfk_cordic (
  input  logic                 clk,
  input  logic                 rst_n,
  input  dfk_pkg::cordic_req_t req,
  output dfk_pkg::cordic_rsp_t rsp
);

  dfk_pkg::cordic_state_t state_r, state_nxt;
  dfk_pkg::cordic_mode_t  mode_r;
  logic [dfk_pkg::STEP_W-1:0] cnt_r;
  logic [33:0]             red_r;
  logic signed [25:0]      m_r;
  logic                    flip_r;
  logic                    zero_r;
  dfk_pkg::wide_t          x_r, y_r;
  dfk_pkg::angle_t         z_r;

  logic signed [25:0] fold_m;
  logic               fold_flip;
  logic [33:0]        red_sub;
  logic signed [53:0] scaled;
  dfk_pkg::wide_t     dx, dy;
  logic               pos_dir;

  always_comb begin
    fold_m    = signed'({1'b0, red_r[24:0]});
    fold_flip = 1'b0;
    if (fold_m >= dfk_pkg::DEG_HALF) fold_m = fold_m - dfk_pkg::DEG_FULL_S;
    if (fold_m > dfk_pkg::DEG_QUARTER) begin
      fold_m    = dfk_pkg::DEG_HALF - fold_m;
      fold_flip = 1'b1;
    end else if (fold_m < -dfk_pkg::DEG_QUARTER) begin
      fold_m    = -dfk_pkg::DEG_HALF - fold_m;
      fold_flip = 1'b1;
    end
  end

  assign red_sub = dfk_pkg::DEG_FULL << cnt_r[2:0];
  assign scaled  = m_r * dfk_pkg::DEG_TO_RAD;
  assign dx      = y_r >>> cnt_r;
  assign dy      = x_r >>> cnt_r;
  // both modes take the same branch: z >= 0 when rotating, y < 0 when vectoring
  assign pos_dir = (mode_r == dfk_pkg::CM_ROTATE) ? (z_r >= 0) : (y_r < 0);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      dfk_pkg::C_IDLE: begin
        if (req.start) begin
          state_nxt = (req.mode == dfk_pkg::CM_ROTATE) ? dfk_pkg::C_REDUCE
                                                       : dfk_pkg::C_ITER;
        end
      end
      dfk_pkg::C_REDUCE: if (cnt_r == '0) state_nxt = dfk_pkg::C_FOLD;
      dfk_pkg::C_FOLD:   state_nxt = dfk_pkg::C_SCALE;
      dfk_pkg::C_SCALE:  state_nxt = dfk_pkg::C_ITER;
      dfk_pkg::C_ITER: begin
        if (cnt_r == dfk_pkg::STEP_W'(dfk_pkg::CORDIC_STEPS - 1)) begin
          state_nxt = dfk_pkg::C_DONE;
        end
      end
      dfk_pkg::C_DONE:   state_nxt = dfk_pkg::C_IDLE;
      default:           state_nxt = dfk_pkg::C_IDLE;
    endcase
  end

  always_comb begin
    rsp.done = (state_r == dfk_pkg::C_DONE);
    rsp.x    = (mode_r == dfk_pkg::CM_ROTATE && flip_r) ? -x_r : x_r;
    rsp.y    = y_r;
    rsp.z    = zero_r ? '0 : z_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= dfk_pkg::C_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      dfk_pkg::C_IDLE: begin
        if (req.start) begin
          mode_r <= req.mode;
          flip_r <= 1'b0;
          zero_r <= 1'b0;
          if (req.mode == dfk_pkg::CM_ROTATE) begin
            red_r <= 34'(req.angle) + dfk_pkg::RED_OFFSET;
            cnt_r <= dfk_pkg::STEP_W'(7);
          end else begin
            cnt_r  <= '0;
            zero_r <= (req.x == 0) && (req.y == 0);
            if (req.x < 0) begin
              x_r <= -req.x;
              y_r <= -req.y;
              z_r <= (req.y >= 0) ? dfk_pkg::PI_Q16 : -dfk_pkg::PI_Q16;
            end else begin
              x_r <= req.x;
              y_r <= req.y;
              z_r <= '0;
            end
          end
        end
      end
      dfk_pkg::C_REDUCE: begin
        // restoring reduction modulo a full turn
        if (red_r >= red_sub) red_r <= red_r - red_sub;
        cnt_r <= cnt_r - 1'b1;
      end
      dfk_pkg::C_FOLD: begin
        m_r    <= fold_m;
        flip_r <= fold_flip;
      end
      dfk_pkg::C_SCALE: begin
        z_r   <= 24'(scaled >>> 32);
        x_r   <= dfk_pkg::GAIN_Q30;
        y_r   <= '0;
        cnt_r <= '0;
      end
      dfk_pkg::C_ITER: begin
        if (pos_dir) begin
          x_r <= x_r - dx;
          y_r <= y_r + dy;
          z_r <= z_r - dfk_pkg::atan_lut(cnt_r);
        end else begin
          x_r <= x_r + dx;
          y_r <= y_r - dy;
          z_r <= z_r + dfk_pkg::atan_lut(cnt_r);
        end
        cnt_r <= cnt_r + 1'b1;
      end
      default: ;
    endcase
  end

  a_done_after_iter: assert property (@(posedge clk) disable iff (!rst_n)
    rsp.done |-> $past(state_r == dfk_pkg::C_ITER))
    else $error("cordic done without finishing iterations");
  a_start_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != dfk_pkg::C_IDLE) |-> !req.start)
    else $error("cordic started while busy");
  a_reduce_to_fold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == dfk_pkg::C_FOLD) |-> (red_r < dfk_pkg::DEG_FULL))
    else $error("angle reduction left a value above a full turn");

endmodule

>>> hdl/dfk_isqrt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dfk_isqrt
// Iterative floor square root of a 64-bit value, one result bit per cycle.
// ----------------------------------------------------------------------------
module dfk_isqrt (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] radicand,
  output logic        done,
  output logic [31:0] root
);

  logic        busy_r, done_r;
  logic [4:0]  cnt_r;
  logic [63:0] rem_r, res_r, bit_r;
  logic [63:0] trial;

  assign trial = res_r + bit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= busy_r && (cnt_r == 5'd31);
      if (start) busy_r <= 1'b1;
      else if (cnt_r == 5'd31) busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= radicand;
      res_r <= '0;
      bit_r <= 64'd1 << 62;
      cnt_r <= '0;
    end else if (busy_r) begin
      if (rem_r >= trial) begin
        rem_r <= rem_r - trial;
        res_r <= (res_r >> 1) + bit_r;
      end else begin
        res_r <= res_r >> 1;
      end
      bit_r <= bit_r >> 2;
      cnt_r <= cnt_r + 1'b1;
    end
  end

  assign done = done_r;
  assign root = res_r[31:0];

endmodule

>>> hdl/dh_forward_kinematics.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dh_forward_kinematics
// A table write leaves the block idle. The time from the compute transfer to
// the pose result is set by the shared CORDIC: two sin/cos per joint, three
// atan2. So do the single-multiplier matrix product and the 32-step
// square root.
// One item at a time; a finished pose waits in the output register.
// Synchronous active-low reset clears the table valid bits and sets joints to 1.
// ----------------------------------------------------------------------------
module dh_forward_kinematics (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  dfk_pkg::in_item_t in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output dfk_pkg::out_item_t out_data,
  input  logic              cfg_we,
  input  logic [3:0]        cfg_wdata
);

  dfk_pkg::ctrl_state_t state_r, state_nxt;
  logic [3:0]                num_joints_r;
  logic [dfk_pkg::JCNT_W-1:0] n_eff, j_r;
  logic [1:0]                psel_r;
  logic [2:0]                cnt_r;
  logic [3:0]                e_r;
  logic [1:0]                k_r;
  logic [1:0]                aidx_r;

  dfk_pkg::wide_t t_r  [12];
  dfk_pkg::wide_t tn_r [12];
  dfk_pkg::wide_t h_r  [12];
  dfk_pkg::wide_t ct_r, st_r, ca_r, sa_r, rl_r, d_r;
  logic signed [71:0] prod_r;
  logic signed [39:0] acc_r;
  logic [63:0]        sq_r;
  logic [31:0]        root_r;
  dfk_pkg::angle_t    yaw_r, pitch_r, roll_r;
  logic               out_valid_r;
  dfk_pkg::out_item_t out_data_r;

  logic                       in_xfer, out_free;
  logic                       ram_we;
  logic [dfk_pkg::ADDR_W-1:0] ram_waddr, ram_raddr;
  logic [31:0]                ram_q;
  dfk_pkg::cordic_req_t       creq;
  dfk_pkg::cordic_rsp_t       crsp;
  logic                       sq_start, sq_done;
  logic [31:0]                sq_root;
  dfk_pkg::wide_t             mul_a, mul_b, prod_sh;
  logic signed [39:0]         acc_fin, acc_clamp;

  assign in_xfer  = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = (state_r != dfk_pkg::S_IDLE);

  always_comb begin
    if (int'(num_joints_r) > dfk_pkg::MAX_JOINTS) n_eff = dfk_pkg::JCNT_W'(dfk_pkg::MAX_JOINTS);
    else n_eff = dfk_pkg::JCNT_W'(num_joints_r);
  end

  assign ram_we    = in_xfer && (in_data.opcode == dfk_pkg::OP_WRITE)
                     && (int'(in_data.joint_index) < dfk_pkg::MAX_JOINTS);
  assign ram_waddr = {dfk_pkg::JOINT_W'(in_data.joint_index), in_data.param_select};
  assign ram_raddr = {j_r[dfk_pkg::JOINT_W-1:0], psel_r};

  dfk_param_ram u_ram (
    .clk(clk), .rst_n(rst_n), .we(ram_we), .waddr(ram_waddr),
    .wdata(in_data.param_value), .raddr(ram_raddr), .rdata(ram_q)
  );

  dfk_cordic u_cordic (.clk(clk), .rst_n(rst_n), .req(creq), .rsp(crsp));

  dfk_isqrt u_isqrt (
    .clk(clk), .rst_n(rst_n), .start(sq_start), .radicand(sq_r),
    .done(sq_done), .root(sq_root)
  );

  // multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    priority case (state_r)
      dfk_pkg::S_HMUL: begin
        unique case (cnt_r)
          3'd0:    begin mul_a = ca_r; mul_b = st_r; end
          3'd1:    begin mul_a = sa_r; mul_b = st_r; end
          3'd2:    begin mul_a = rl_r; mul_b = ct_r; end
          3'd3:    begin mul_a = ca_r; mul_b = ct_r; end
          3'd4:    begin mul_a = sa_r; mul_b = ct_r; end
          3'd5:    begin mul_a = rl_r; mul_b = st_r; end
          default: ;
        endcase
      end
      dfk_pkg::S_MAT: begin
        if (k_r != 2'd3) begin
          mul_a = t_r[{e_r[3:2], k_r}];
          mul_b = h_r[{k_r, e_r[1:0]}];
        end
      end
      dfk_pkg::S_SQ: begin
        if (cnt_r == 3'd0) begin mul_a = t_r[0]; mul_b = t_r[0]; end
        else begin mul_a = t_r[4]; mul_b = t_r[4]; end
      end
      default: ;
    endcase
  end

  assign prod_sh = 36'(prod_r >>> 30);
  assign acc_fin = acc_r + 40'(prod_sh);

  always_comb begin
    acc_clamp = acc_fin;
    if (e_r[1:0] == 2'd3) begin
      if (acc_fin > 40'sd2147483647) acc_clamp = 40'sd2147483647;
      else if (acc_fin < -40'sd2147483648) acc_clamp = -40'sd2147483648;
    end else begin
      if (acc_fin > 40'sd2147483648) acc_clamp = 40'sd2147483648;
      else if (acc_fin < -40'sd2147483648) acc_clamp = -40'sd2147483648;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      dfk_pkg::S_IDLE: begin
        if (in_xfer && in_data.opcode == dfk_pkg::OP_COMPUTE) begin
          state_nxt = (n_eff == '0) ? dfk_pkg::S_SQ : dfk_pkg::S_RD;
        end
      end
      dfk_pkg::S_RD: state_nxt = dfk_pkg::S_LD;
      dfk_pkg::S_LD: begin
        priority if (psel_r == dfk_pkg::PSEL_THETA || psel_r == dfk_pkg::PSEL_ALPHA)
          state_nxt = dfk_pkg::S_TRIG_WT;
        else if (psel_r == dfk_pkg::PSEL_LEN) state_nxt = dfk_pkg::S_RD;
        else state_nxt = dfk_pkg::S_HMUL;
      end
      dfk_pkg::S_TRIG_WT: if (crsp.done) state_nxt = dfk_pkg::S_RD;
      dfk_pkg::S_HMUL:    if (cnt_r == 3'd6) state_nxt = dfk_pkg::S_MAT;
      dfk_pkg::S_MAT:     if (k_r == 2'd3 && e_r == 4'd11) state_nxt = dfk_pkg::S_NEXT;
      dfk_pkg::S_NEXT: begin
        state_nxt = (j_r + 1'b1 == n_eff) ? dfk_pkg::S_SQ : dfk_pkg::S_RD;
      end
      dfk_pkg::S_SQ:      if (cnt_r == 3'd2) state_nxt = dfk_pkg::S_SQRT_GO;
      dfk_pkg::S_SQRT_GO: state_nxt = dfk_pkg::S_SQRT_WT;
      dfk_pkg::S_SQRT_WT: if (sq_done) state_nxt = dfk_pkg::S_ATAN_GO;
      dfk_pkg::S_ATAN_GO: state_nxt = dfk_pkg::S_ATAN_WT;
      dfk_pkg::S_ATAN_WT: begin
        if (crsp.done) state_nxt = (aidx_r == 2'd2) ? dfk_pkg::S_OUT : dfk_pkg::S_ATAN_GO;
      end
      dfk_pkg::S_OUT:     if (out_free) state_nxt = dfk_pkg::S_IDLE;
      default:            state_nxt = dfk_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    creq       = '0;
    creq.mode  = dfk_pkg::CM_ROTATE;
    creq.angle = ram_q;
    sq_start   = (state_r == dfk_pkg::S_SQRT_GO);
    if (state_r == dfk_pkg::S_LD
        && (psel_r == dfk_pkg::PSEL_THETA || psel_r == dfk_pkg::PSEL_ALPHA)) begin
      creq.start = 1'b1;
    end
    if (state_r == dfk_pkg::S_ATAN_GO) begin
      creq.start = 1'b1;
      creq.mode  = dfk_pkg::CM_VECTOR;
      unique case (aidx_r)
        2'd0:    begin creq.y = t_r[4];  creq.x = t_r[0]; end
        2'd1:    begin creq.y = -t_r[8]; creq.x = 36'({4'd0, root_r}); end
        default: begin creq.y = t_r[9];  creq.x = t_r[10]; end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= dfk_pkg::S_IDLE;
      num_joints_r <= 4'd1;
      out_valid_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) num_joints_r <= cfg_wdata;
      if (state_r == dfk_pkg::S_OUT && out_free) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
    unique case (state_r)
      dfk_pkg::S_IDLE: begin
        j_r    <= '0;
        psel_r <= dfk_pkg::PSEL_THETA;
        cnt_r  <= '0;
        aidx_r <= '0;
        for (int i = 0; i < 12; i++) begin
          t_r[i] <= (i == 0 || i == 5 || i == 10) ? dfk_pkg::ONE_Q30 : '0;
        end
      end
      dfk_pkg::S_LD: begin
        if (psel_r == dfk_pkg::PSEL_LEN) begin
          rl_r   <= 36'(signed'(ram_q));
          psel_r <= dfk_pkg::PSEL_OFS;
        end else if (psel_r == dfk_pkg::PSEL_OFS) begin
          d_r   <= 36'(signed'(ram_q));
          cnt_r <= '0;
        end
      end
      dfk_pkg::S_TRIG_WT: begin
        if (crsp.done) begin
          if (psel_r == dfk_pkg::PSEL_THETA) begin
            ct_r <= crsp.x;
            st_r <= crsp.y;
          end else begin
            ca_r <= crsp.x;
            sa_r <= crsp.y;
          end
          psel_r <= psel_r + 1'b1;
        end
      end
      dfk_pkg::S_HMUL: begin
        // each step stores the registered product of the previous step
        unique case (cnt_r)
          3'd0: begin
            h_r[0] <= ct_r; h_r[4] <= st_r; h_r[8] <= '0;
            h_r[9] <= sa_r; h_r[10] <= ca_r; h_r[11] <= d_r;
          end
          3'd1:    h_r[1]  <= -prod_sh;
          3'd2:    h_r[2]  <= prod_sh;
          3'd3:    h_r[3]  <= prod_sh;
          3'd4:    h_r[5]  <= prod_sh;
          3'd5:    h_r[6]  <= -prod_sh;
          default: h_r[7]  <= prod_sh;
        endcase
        cnt_r <= cnt_r + 1'b1;
        e_r   <= '0;
        k_r   <= '0;
      end
      dfk_pkg::S_MAT: begin
        unique case (k_r)
          2'd0:    acc_r <= (e_r[1:0] == 2'd3) ? 40'(t_r[{e_r[3:2], 2'd3}]) : '0;
          2'd3: begin
            tn_r[e_r] <= 36'(acc_clamp);
            e_r       <= e_r + 1'b1;
          end
          default: acc_r <= acc_fin;
        endcase
        k_r <= k_r + 1'b1;
      end
      dfk_pkg::S_NEXT: begin
        for (int i = 0; i < 12; i++) t_r[i] <= tn_r[i];
        j_r    <= j_r + 1'b1;
        psel_r <= dfk_pkg::PSEL_THETA;
        cnt_r  <= '0;
      end
      dfk_pkg::S_SQ: begin
        if (cnt_r == 3'd1) sq_r <= 64'(prod_r);
        if (cnt_r == 3'd2) sq_r <= sq_r + 64'(prod_r);
        cnt_r <= cnt_r + 1'b1;
      end
      dfk_pkg::S_SQRT_WT: if (sq_done) root_r <= sq_root;
      dfk_pkg::S_ATAN_WT: begin
        if (crsp.done) begin
          unique case (aidx_r)
            2'd0:    yaw_r   <= crsp.z;
            2'd1:    pitch_r <= crsp.z;
            default: roll_r  <= crsp.z;
          endcase
          aidx_r <= aidx_r + 1'b1;
        end
      end
      dfk_pkg::S_OUT: begin
        if (out_free) begin
          out_data_r.yaw_angle   <= 32'(yaw_r);
          out_data_r.pitch_angle <= 32'(pitch_r);
          out_data_r.roll_angle  <= 32'(roll_r);
          out_data_r.pos_x       <= t_r[3][31:0];
          out_data_r.pos_y       <= t_r[7][31:0];
          out_data_r.pos_z       <= t_r[11][31:0];
        end
      end
      default: ;
    endcase
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_joint_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == dfk_pkg::S_RD) |-> (j_r < n_eff))
    else $error("joint counter ran past the configured count");
  a_compute_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && in_data.opcode == dfk_pkg::OP_COMPUTE) |=> (state_r != dfk_pkg::S_IDLE))
    else $error("compute transfer did not start the sequencer");
  a_cordic_done_waited: assert property (@(posedge clk) disable iff (!rst_n)
    crsp.done |-> (state_r == dfk_pkg::S_TRIG_WT || state_r == dfk_pkg::S_ATAN_WT))
    else $error("cordic result arrived outside a wait state");
  a_no_write_busy: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (state_r == dfk_pkg::S_IDLE))
    else $error("table written during a pose computation");

endmodule

>>> tb/sv/tb_dh_forward_kinematics.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_dh_forward_kinematics
// Self-checking bench for the DH forward kinematics block. A directed table of
// joint parameter writes and pose requests hits the extremes and special
// cases. Random joint tables and poses follow under several joint counts and
// handshake pressure. Every pose is checked field by field against an
// in-bench bit-exact model of the fixed-point datapath.
// ----------------------------------------------------------------------------
module tb_dh_forward_kinematics;

  localparam longint ATAN_T [16] = '{51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
                                     256, 128, 64, 32, 16, 8, 4, 2};
  localparam longint GAIN = 652032874;
  localparam longint D2R = 74961321;
  localparam longint PI16 = 205887;
  localparam longint DFULL = 360 * 65536;
  localparam longint DHALF = 180 * 65536;
  localparam longint DQUART = 90 * 65536;
  localparam longint ONE30 = 64'sd1 <<< 30;
  localparam longint ECLAMP = 64'sd1 <<< 31;
  localparam longint I32MIN = -(64'sd1 <<< 31);
  localparam longint I32MAX = (64'sd1 <<< 31) - 1;

  typedef struct {
    int                cfg;      // joint count to set before the row, -1 keeps it
    dfk_pkg::in_item_t item;
    bit                lit;      // expected pose typed in as all zeros
  } dir_row_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  dfk_pkg::in_item_t  in_data = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  dfk_pkg::out_item_t out_data;
  logic               cfg_we = 1'b0;
  logic [3:0]         cfg_wdata = '0;

  logic [31:0]        dh_table [32];
  logic [3:0]         joint_count;
  dfk_pkg::out_item_t pose_q [$];
  dir_row_t           dir_rows [$];
  int                 gap_pct = 0;
  int                 stall_pct = 0;
  int                 mismatches = 0;

  dh_forward_kinematics DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic longint clampl(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic void cordic_sincos(input longint deg, output longint c, output longint s);
    longint m, x, y, z, dx, dy;
    bit flip;
    m = deg % DFULL;
    x = GAIN;
    y = 0;
    flip = 1'b0;
    if (m < 0) m += DFULL;
    if (m >= DHALF) m -= DFULL;
    if (m > DQUART) begin
      m = DHALF - m;
      flip = 1'b1;
    end else if (m < -DQUART) begin
      m = -DHALF - m;
      flip = 1'b1;
    end
    z = (m * D2R) >>> 32;
    for (int i = 0; i < 16; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= ATAN_T[i];
      end else begin
        x += dx; y -= dy; z += ATAN_T[i];
      end
    end
    c = flip ? -x : x;
    s = y;
  endfunction

  function automatic longint cordic_atan2(longint y, longint x);
    longint z, dx, dy;
    z = 0;
    if (x == 0 && y == 0) return 0;
    if (x < 0) begin
      z = (y >= 0) ? PI16 : -PI16;
      x = -x;
      y = -y;
    end
    for (int i = 0; i < 16; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y < 0) begin
        x -= dx; y += dy; z -= ATAN_T[i];
      end else begin
        x += dx; y -= dy; z += ATAN_T[i];
      end
    end
    return z;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= res + b) begin
        n -= res + b;
        res = (res >> 1) + b;
      end else res >>= 1;
      b >>= 2;
    end
    return res;
  endfunction

  function automatic dfk_pkg::out_item_t pose_model();
    longint t [3][4];
    longint h [3][4];
    longint nr [4];
    longint ct, st, ca, sa, rl, acc;
    longint unsigned m0, m1;
    int n;
    dfk_pkg::out_item_t o;
    n = (joint_count > dfk_pkg::MAX_JOINTS) ? dfk_pkg::MAX_JOINTS : int'(joint_count);
    for (int r = 0; r < 3; r++)
      for (int c = 0; c < 4; c++) t[r][c] = (r == c) ? ONE30 : 0;
    for (int j = 0; j < n; j++) begin
      rl = longint'($signed(dh_table[j*4 + dfk_pkg::PSEL_LEN]));
      cordic_sincos(longint'($signed(dh_table[j*4 + dfk_pkg::PSEL_THETA])), ct, st);
      cordic_sincos(longint'($signed(dh_table[j*4 + dfk_pkg::PSEL_ALPHA])), ca, sa);
      h[0][0] = ct; h[0][1] = -((ca * st) >>> 30); h[0][2] = (sa * st) >>> 30;
      h[0][3] = (rl * ct) >>> 30;
      h[1][0] = st; h[1][1] = (ca * ct) >>> 30; h[1][2] = -((sa * ct) >>> 30);
      h[1][3] = (rl * st) >>> 30;
      h[2][0] = 0; h[2][1] = sa; h[2][2] = ca;
      h[2][3] = longint'($signed(dh_table[j*4 + dfk_pkg::PSEL_OFS]));
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 4; c++) begin
          acc = (c == 3) ? t[r][3] : 0;
          for (int k = 0; k < 3; k++) acc += (t[r][k] * h[k][c]) >>> 30;
          nr[c] = (c == 3) ? clampl(acc, I32MIN, I32MAX) : clampl(acc, -ECLAMP, ECLAMP);
        end
        for (int c = 0; c < 4; c++) t[r][c] = nr[c];
      end
    end
    m0 = (t[0][0] < 0) ? -t[0][0] : t[0][0];
    m1 = (t[1][0] < 0) ? -t[1][0] : t[1][0];
    o.yaw_angle   = 32'(clampl(cordic_atan2(t[1][0], t[0][0]), I32MIN, I32MAX));
    o.pitch_angle = 32'(clampl(cordic_atan2(-t[2][0], longint'(int_sqrt(m0*m0 + m1*m1))),
                               I32MIN, I32MAX));
    o.roll_angle  = 32'(clampl(cordic_atan2(t[2][1], t[2][2]), I32MIN, I32MAX));
    o.pos_x = 32'(t[0][3]);
    o.pos_y = 32'(t[1][3]);
    o.pos_z = 32'(t[2][3]);
    return o;
  endfunction

  // called at a falling edge, returns at a falling edge
  task automatic send(input dfk_pkg::in_item_t it, input bit lit);
    while ($urandom_range(99) < gap_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_data = it;
    do @(posedge clk); while (in_stall);
    if (it.opcode == dfk_pkg::OP_WRITE)
      dh_table[it.joint_index*4 + it.param_select] = it.param_value;
    else pose_q.push_back(lit ? dfk_pkg::out_item_t'('0) : pose_model());
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid = 1'b0;
    while (pose_q.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic set_joints(input logic [3:0] v);
    drain();
    cfg_we = 1'b1;
    cfg_wdata = v;
    @(negedge clk);
    cfg_we = 1'b0;
    joint_count = v;
  endtask

  function automatic void add_row(int cfg, logic op, logic [2:0] ji, logic [1:0] ps,
                                  logic [31:0] val, bit lit);
    dir_row_t row;
    row.cfg = cfg;
    row.item.opcode = op;
    row.item.joint_index = ji;
    row.item.param_select = ps;
    row.item.param_value = val;
    row.lit = lit;
    dir_rows.push_back(row);
  endfunction

  function automatic logic [31:0] rand_value(logic [1:0] ps);
    int sel;
    sel = $urandom_range(9);
    if (sel == 0) return $urandom();
    if (sel == 1) return $urandom_range(1) ? 32'h7fffffff : 32'h80000000;
    if (ps == dfk_pkg::PSEL_THETA || ps == dfk_pkg::PSEL_ALPHA)
      return 32'($signed($urandom_range(1440)) - 720) <<< 16 | 32'($urandom_range(65535));
    return 32'($signed($urandom_range(2000)) - 1000) <<< 16 | 32'($urandom_range(65535));
  endfunction

  always @(negedge clk) out_stall = ($urandom_range(99) < stall_pct);

  always @(posedge clk) begin
    dfk_pkg::out_item_t exp_pose;
    logic [191:0] ev, av;
    if (rst_n && out_valid && !out_stall) begin
      if (pose_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected pose transfer %h", out_data);
      end else begin
        exp_pose = pose_q.pop_front();
        ev = exp_pose;
        av = out_data;
        for (int k = 0; k < 6; k++)
          if (ev[191 - 32*k -: 32] !== av[191 - 32*k -: 32]) begin
            mismatches++;
            if (mismatches <= 10)
              $display("pose field %0d mismatch: expected %h, got %h", k,
                       ev[191 - 32*k -: 32], av[191 - 32*k -: 32]);
          end
      end
    end
  end

  initial begin
    #20ms;
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    dfk_pkg::in_item_t it;
    int n_items;
    logic [3:0] cfg_set [10];
    cfg_set = '{15, 8, 2, 7, 3, 1, 0, 5, 8, 4};
    for (int i = 0; i < 32; i++) dh_table[i] = '0;
    joint_count = 4'd1;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // zero joints gives the identity rotation and a zero position
    add_row(0, dfk_pkg::OP_COMPUTE, 0, 0, 0, 0);
    add_row(1, dfk_pkg::OP_COMPUTE, 0, 0, 0, 0);
    add_row(-1, dfk_pkg::OP_WRITE, 0, dfk_pkg::PSEL_THETA, 32'd90 << 16, 0);
    add_row(-1, dfk_pkg::OP_WRITE, 0, dfk_pkg::PSEL_ALPHA, -(32'd180 << 16), 0);
    add_row(-1, dfk_pkg::OP_WRITE, 0, dfk_pkg::PSEL_LEN, 32'h7fffffff, 0);
    add_row(-1, dfk_pkg::OP_WRITE, 0, dfk_pkg::PSEL_OFS, 32'h80000000, 0);
    add_row(-1, dfk_pkg::OP_COMPUTE, 0, 0, 0, 0);
    add_row(-1, dfk_pkg::OP_WRITE, 0, dfk_pkg::PSEL_THETA, 32'h80000000, 0);
    add_row(-1, dfk_pkg::OP_WRITE, 0, dfk_pkg::PSEL_ALPHA, 32'h7fffffff, 0);
    add_row(-1, dfk_pkg::OP_WRITE, 7, dfk_pkg::PSEL_THETA, -(32'd90 << 16), 0);
    add_row(-1, dfk_pkg::OP_WRITE, 7, dfk_pkg::PSEL_ALPHA, 32'd90 << 16, 0);
    add_row(-1, dfk_pkg::OP_WRITE, 7, dfk_pkg::PSEL_LEN, 32'h80000000, 0);
    add_row(-1, dfk_pkg::OP_WRITE, 7, dfk_pkg::PSEL_OFS, 32'h7fffffff, 0);
    add_row(8, dfk_pkg::OP_COMPUTE, 0, 0, 0, 0);
    // joint count above the table size clamps, compute ignores its other fields
    add_row(15, dfk_pkg::OP_COMPUTE, 7, 3, 32'hffffffff, 0);
    add_row(-1, dfk_pkg::OP_WRITE, 3, dfk_pkg::PSEL_LEN, 32'd100 << 16, 0);
    add_row(-1, dfk_pkg::OP_WRITE, 3, dfk_pkg::PSEL_THETA, 32'd45 << 16, 0);
    add_row(-1, dfk_pkg::OP_COMPUTE, 5, 2, 32'h5a5a5a5a, 0);
    add_row(0, dfk_pkg::OP_COMPUTE, 0, 0, 0, 0);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].cfg >= 0) set_joints(4'(dir_rows[i].cfg));
      send(dir_rows[i].item, dir_rows[i].lit);
    end

    n_items = 0;
    for (int ph = 0; ph < 10; ph++) begin
      set_joints(cfg_set[ph]);
      case (ph % 4)
        0: begin gap_pct = 0;  stall_pct = 0;  end
        1: begin gap_pct = 68; stall_pct = 0;  end
        2: begin gap_pct = 0;  stall_pct = 68; end
        default: begin gap_pct = 15; stall_pct = 15; end
      endcase
      repeat (75) begin
        it.opcode = ($urandom_range(7) == 0) ? dfk_pkg::OP_COMPUTE : dfk_pkg::OP_WRITE;
        it.joint_index = 3'($urandom_range(7));
        it.param_select = 2'($urandom_range(3));
        it.param_value = (it.opcode == dfk_pkg::OP_COMPUTE) ? 32'($urandom())
                                                            : rand_value(it.param_select);
        send(it, 0);
        n_items++;
      end
    end

    gap_pct = 0;
    in_valid = 1'b0;
    while (pose_q.size() != 0) @(negedge clk);
    stall_pct = 0;
    repeat (50) @(negedge clk);
    if (mismatches == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule

>>> sim.f
hdl/dfk_pkg.sv
hdl/dfk_param_ram.sv
hdl/dfk_cordic.sv
hdl/dfk_isqrt.sv
hdl/dh_forward_kinematics.sv
tb/sv/tb_dh_forward_kinematics.sv
